### rtl/ifp_pkg.sv
// Package for the IPv4 fragment planner: sequencer state type, status codes
// and default constants.
// No dependencies.
`default_nettype none

package ifp_pkg;

   localparam int unsigned MAX_FRAGMENTS_DEFAULT = 64;
   localparam logic [15:0] MPS_RESET             = 16'd1514;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DF    = 2'd1,
      ST_MANY  = 2'd2,
      ST_SMALL = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MULT,
      S_COUNT,
      S_EMIT,
      S_DROP
   } state_type;

endpackage

`default_nettype wire

### rtl/ipv4_fragment_planner.sv
// IPv4 fragment planner top level: sequencer with its own adders and comparators.
// Depends on ifp_pkg.
//
//   channel  dir  handshake               payload
//   req      in   req_valid/req_ready     packet descriptor
//   rsp      out  rsp_valid/rsp_ready     fragment or drop descriptor
//   csr      in   csr_valid/csr_ready     max_packet_size
//
// A packet is taken in the idle state, then passes the checks (header sum,
// count multiply, limit compare) and yields one fragment word per cycle while
// rsp does not stall. The fragment loop is paced by the single output register:
// a stall on rsp holds the loop. A DF or size drop goes from the header check
// to the drop word, a fragment-limit drop after the multiply and compare.
// req_ready is high only while idle;
// the next packet is taken while the last word still waits on rsp.
// Synchronous reset clears control state and sets max_packet_size to 1514.
`default_nettype none

module ipv4_fragment_planner
   import ifp_pkg::*;
#(
   parameter int unsigned MAX_FRAGMENTS = MAX_FRAGMENTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [6:0]  req_link_header_len,
   input  wire logic [3:0]  req_ip_header_words,
   input  wire logic [15:0] req_frame_len,
   input  wire logic        req_dont_fragment,
   input  wire logic [12:0] req_orig_frag_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_frag_index,
   output logic [15:0]      rsp_payload_start,
   output logic [15:0]      rsp_chunk_len,
   output logic [15:0]      rsp_out_frame_len,
   output logic [12:0]      rsp_new_frag_offset,
   output logic             rsp_more_fragments,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_max_packet_size
);

   localparam logic [5:0] LastIdx = 6'(MAX_FRAGMENTS - 1);

   state_type   state_ff, state_in;
   logic [15:0] mps_ff;

   logic [6:0]  link_ff;
   logic [3:0]  ihl_ff;
   logic [15:0] flen_ff;
   logic        df_ff;
   logic [12:0] ooff_ff;

   logic [7:0]  common_ff, common_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] raw_ff, raw_in;
   logic [21:0] prod_ff, prod_in;
   logic [15:0] done_ff, done_in;
   logic [5:0]  idx_ff, idx_in;
   status_type  drop_ff, drop_in;

   logic        ov_ff, ov_in;
   logic [5:0]  o_idx_ff, o_idx_in;
   logic [15:0] o_start_ff, o_start_in;
   logic [15:0] o_chunk_ff, o_chunk_in;
   logic [15:0] o_flen_ff, o_flen_in;
   logic [12:0] o_off_ff, o_off_in;
   logic        o_mf_ff, o_mf_in;
   status_type  o_st_ff, o_st_in;
   logic        o_last_ff, o_last_in;

   logic        out_free;
   logic [7:0]  common_c;
   logic        too_small;
   logic [15:0] step;
   logic [15:0] rem;
   logic [15:0] chunk;
   logic        mf;
   logic [22:0] prod_raw;
   logic [22:0] prod_step;
   logic        too_many;

   assign out_free  = !ov_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   assign common_c  = 8'(link_ff) + {2'b00, ihl_ff, 2'b00};
   assign too_small = ({1'b0, mps_ff} < (17'(common_c) + 17'd8))
                      || (flen_ff < 16'(common_c));
   assign step      = {raw_ff[15:3], 3'b000};
   assign rem       = total_ff - done_ff;
   assign chunk     = (rem < raw_ff) ? rem : step;
   assign mf        = ((17'(done_ff) + 17'(chunk)) != 17'(total_ff));
   assign prod_raw  = 23'(prod_ff) + 23'(raw_ff);
   assign prod_step = 23'(prod_ff) + 23'(step);
   assign too_many  = (23'(total_ff) >= prod_raw) && (23'(total_ff) > prod_step);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (df_ff || too_small) state_in = S_DROP;
            else state_in = S_MULT;
         end
         S_MULT: begin
            state_in = S_COUNT;
         end
         S_COUNT: begin
            if (too_many) state_in = S_DROP;
            else state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free && !mf) state_in = S_IDLE;
         end
         S_DROP: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      common_in  = common_ff;
      total_in   = total_ff;
      raw_in     = raw_ff;
      prod_in    = prod_ff;
      done_in    = done_ff;
      idx_in     = idx_ff;
      drop_in    = drop_ff;
      ov_in      = ov_ff && !rsp_ready;
      o_idx_in   = o_idx_ff;
      o_start_in = o_start_ff;
      o_chunk_in = o_chunk_ff;
      o_flen_in  = o_flen_ff;
      o_off_in   = o_off_ff;
      o_mf_in    = o_mf_ff;
      o_st_in    = o_st_ff;
      o_last_in  = o_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            done_in = '0;
            idx_in  = '0;
         end
         S_CHECK: begin
            common_in = common_c;
            total_in  = flen_ff - 16'(common_c);
            raw_in    = mps_ff - 16'(common_c);
            drop_in   = df_ff ? ST_DF : ST_SMALL;
         end
         S_MULT: begin
            prod_in = 22'(LastIdx) * 22'(step);
         end
         S_COUNT: begin
            drop_in = ST_MANY;
         end
         S_EMIT: begin
            if (out_free) begin
               ov_in      = 1'b1;
               o_idx_in   = idx_ff;
               o_start_in = done_ff;
               o_chunk_in = chunk;
               o_flen_in  = 16'(common_ff) + chunk;
               o_off_in   = ooff_ff + done_ff[15:3];
               o_mf_in    = mf;
               o_st_in    = ST_OK;
               o_last_in  = !mf;
               done_in    = done_ff + chunk;
               idx_in     = idx_ff + 6'd1;
            end
         end
         S_DROP: begin
            if (out_free) begin
               ov_in      = 1'b1;
               o_idx_in   = '0;
               o_start_in = '0;
               o_chunk_in = '0;
               o_flen_in  = '0;
               o_off_in   = '0;
               o_mf_in    = 1'b0;
               o_st_in    = drop_ff;
               o_last_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
         mps_ff   <= MPS_RESET;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         if (csr_valid && csr_ready) mps_ff <= csr_max_packet_size;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         link_ff <= req_link_header_len;
         ihl_ff  <= req_ip_header_words;
         flen_ff <= req_frame_len;
         df_ff   <= req_dont_fragment;
         ooff_ff <= req_orig_frag_offset;
      end
      common_ff  <= common_in;
      total_ff   <= total_in;
      raw_ff     <= raw_in;
      prod_ff    <= prod_in;
      done_ff    <= done_in;
      idx_ff     <= idx_in;
      drop_ff    <= drop_in;
      o_idx_ff   <= o_idx_in;
      o_start_ff <= o_start_in;
      o_chunk_ff <= o_chunk_in;
      o_flen_ff  <= o_flen_in;
      o_off_ff   <= o_off_in;
      o_mf_ff    <= o_mf_in;
      o_st_ff    <= o_st_in;
      o_last_ff  <= o_last_in;
   end

   assign rsp_valid           = ov_ff;
   assign rsp_frag_index      = o_idx_ff;
   assign rsp_payload_start   = o_start_ff;
   assign rsp_chunk_len       = o_chunk_ff;
   assign rsp_out_frame_len   = o_flen_ff;
   assign rsp_new_frag_offset = o_off_ff;
   assign rsp_more_fragments  = o_mf_ff;
   assign rsp_status          = o_st_ff;
   assign rsp_last            = o_last_ff;

`ifndef SYNTHESIS
   a_drop_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_last && (rsp_frag_index == 6'd0))
      else $error("drop word without last or with nonzero index");

   a_mf_vs_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_more_fragments == !rsp_last))
      else $error("more_fragments disagrees with last");

   a_index_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frag_index <= LastIdx))
      else $error("fragment index beyond limit");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) && out_free |=> rsp_valid)
      else $error("emitted word not presented");
`endif

endmodule

`default_nettype wire
